// ===== sv/text_line_numberer_assert.svh =====
`ifndef TEXT_LINE_NUMBERER_ASSERT_SVH
`define TEXT_LINE_NUMBERER_ASSERT_SVH

// same-cycle implication
`define TLN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("tln check failed in the same cycle");

// next-cycle implication
`define TLN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("tln check failed one cycle later");

`endif

// ===== sv/tln_pkg.sv =====
package tln_pkg;

	localparam int NUM_DIGITS = 6;
	localparam int IDX_W      = $clog2(NUM_DIGITS + 2);

	localparam logic [7:0] NL_BYTE     = 8'h0A;
	localparam logic [7:0] TAB_BYTE    = 8'h09;
	localparam logic [7:0] SPACE_BYTE  = 8'h20;
	localparam logic [7:0] DIGIT0_BYTE = 8'h30;
	localparam logic [7:0] DIGIT9_BYTE = 8'h39;

	localparam logic [1:0] MODE_PASS     = 2'd0;
	localparam logic [1:0] MODE_ALL      = 2'd1;
	localparam logic [1:0] MODE_NONBLANK = 2'd2;

	typedef logic [7:0]                  byte_t;
	typedef logic [NUM_DIGITS-1:0][3:0]  bcd_t;
	typedef logic [NUM_DIGITS-1:0][7:0]  digit_chars_t;

	typedef struct packed {
		byte_t        in_byte;
		logic         prefix;
		digit_chars_t chars;
	} item_t;

	function automatic logic bcd_is_max(bcd_t v);
		logic m;
		m = 1'b1;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (v[d] != 4'd9) begin
				m = 1'b0;
			end
		end
		return m;
	endfunction

	function automatic bcd_t bcd_inc(bcd_t v);
		bcd_t r;
		logic carry;
		r     = v;
		carry = !bcd_is_max(v);
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (carry) begin
				if (v[d] < 4'd9) begin
					r[d]  = v[d] + 4'd1;
					carry = 1'b0;
				end else begin
					r[d] = 4'd0;
				end
			end
		end
		return r;
	endfunction

	// leading zeros become spaces, units digit always shown
	function automatic digit_chars_t fmt_chars(bcd_t v);
		digit_chars_t c;
		logic seen;
		seen = 1'b0;
		for (int d = NUM_DIGITS - 1; d >= 0; d--) begin
			if (v[d] != 4'd0 || d == 0) begin
				seen = 1'b1;
			end
			c[d] = seen ? (DIGIT0_BYTE + {4'd0, v[d]}) : SPACE_BYTE;
		end
		return c;
	endfunction

endpackage

// ===== sv/tln_if.sv =====
interface tln_in_if import tln_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  start_of_file;

	modport source (output valid, output in_byte, output start_of_file, input ready);
	modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

interface tln_out_if import tln_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== sv/tln_line_ctrl.sv =====
module tln_line_ctrl import tln_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  byte_t      in_byte,
	input  logic       start_of_file,
	input  logic       accept,
	output item_t      item
);

	logic [1:0] mode_q;
	logic       after_nl_q;
	bcd_t       line_num_q;
	logic       prefix;

	always_comb begin
		case (mode_q)
			MODE_ALL:      prefix = start_of_file || after_nl_q;
			MODE_NONBLANK: prefix = start_of_file || (after_nl_q && in_byte != NL_BYTE);
			default:       prefix = 1'b0;
		endcase
	end

	assign item.in_byte = in_byte;
	assign item.prefix  = prefix;
	assign item.chars   = fmt_chars(line_num_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_ALL;
			after_nl_q <= 1'b0;
			line_num_q <= bcd_t'(1);
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (accept) begin
				after_nl_q <= (in_byte == NL_BYTE);
				if (prefix) begin
					line_num_q <= bcd_inc(line_num_q);
				end
			end
		end
	end

endmodule

// ===== sv/tln_emitter.sv =====
module tln_emitter import tln_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	output logic             accept,
	tln_in_if.sink           in_ch,
	tln_out_if.source        out_ch
);

	logic             valid_s1;
	byte_t            byte_s1;
	logic             pfx_s1;
	digit_chars_t     chars_s1;
	logic [IDX_W-1:0] idx_q;

	logic  out_valid_q;
	byte_t out_byte_q;
	logic  out_last_q;

	logic  out_free;
	logic  at_byte;
	logic  at_tab;
	logic  move;
	logic  done;
	logic  in_ready;
	byte_t next_char;

	assign out_free = !out_valid_q || out_ch.ready;
	assign at_byte  = !pfx_s1 || (idx_q == IDX_W'(NUM_DIGITS + 1));
	assign at_tab   = (idx_q == IDX_W'(NUM_DIGITS));
	assign move     = valid_s1 && out_free;
	assign done     = move && at_byte;
	assign in_ready = !valid_s1 || done;
	assign accept   = in_ch.valid && in_ready;

	always_comb begin
		if (at_byte) begin
			next_char = byte_s1;
		end else if (at_tab) begin
			next_char = TAB_BYTE;
		end else begin
			next_char = chars_s1[NUM_DIGITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				idx_q    <= '0;
			end else begin
				if (done) begin
					valid_s1 <= 1'b0;
				end
				if (move) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= item.in_byte;
			pfx_s1   <= item.prefix;
			chars_s1 <= item.chars;
		end else if (move && !at_byte && !at_tab) begin
			chars_s1 <= digit_chars_t'(chars_s1 << 8);
		end
		if (move) begin
			out_byte_q <= next_char;
			out_last_q <= at_byte;
		end
	end

	assign in_ch.ready     = in_ready;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.last     = out_last_q;

endmodule

// ===== sv/text_line_numberer.sv =====
// an accepted byte is held in the stage-one register, then in the output register
// throughput: one byte per cycle while no line starts and the output is not stalled
// a line start occupies NUM_DIGITS + 2 output transfers (8), input waits meanwhile
// the rate is set by the single output register, one byte per cycle while it is not stalled
// reset: mode numbers every line, line number 1, no line pending, channels empty
module text_line_numberer import tln_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	tln_in_if.sink     in_ch,
	tln_out_if.source  out_ch
);

	item_t item;
	logic  accept;

	tln_line_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_byte       (in_ch.in_byte),
		.start_of_file (in_ch.start_of_file),
		.accept        (accept),
		.item          (item)
	);

	tln_emitter u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.accept (accept),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// ===== sv/tln_checker.sv =====
`include "text_line_numberer_assert.svh"

module tln_checker import tln_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  out_valid,
	input logic  out_ready,
	input byte_t out_byte,
	input logic  last
);

	logic stalled;
	logic prefix_char;
	logic tab_xfer;

	assign stalled     = out_valid && !out_ready;
	assign prefix_char = out_byte == SPACE_BYTE || out_byte == TAB_BYTE ||
		(out_byte >= DIGIT0_BYTE && out_byte <= DIGIT9_BYTE);
	assign tab_xfer    = out_valid && out_ready && !last && out_byte == TAB_BYTE;

	// a stalled result holds
	`TLN_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(out_byte) && $stable(last))

	// prefix bytes are spaces, digits or the tab
	`TLN_ASSERT_NOW(a_prefix_chars, clk, arst_n, out_valid && !last, prefix_char)

	// the tab transfer is followed at once by the byte itself
	`TLN_ASSERT_NEXT(a_tab_then_byte, clk, arst_n, tab_xfer, out_valid && last)

endmodule

bind text_line_numberer tln_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.last      (out_ch.last)
);

// ===== sim/tln_checker.sv =====
`timescale 1ns / 1ps

module tln_tb_checker import tln_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	tln_in_if          in_ch,
	tln_out_if         out_ch,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		byte_t data;
		logic  last;
	} out_char_t;

	out_char_t  formatted_q[$];
	logic [1:0] mode;
	logic       after_nl;
	bcd_t       line_num;
	int         errors = 0;

	task automatic report(input string what, input int got, input int want);
		errors++;
		if (errors <= 40) begin
			$display("%0t: %s mismatch, got %02h want %02h", $time, what, got, want);
		end
	endtask

	// all nines holds, otherwise ripple the carry up
	function automatic bcd_t next_line_num(bcd_t v);
		bcd_t r;
		r = v;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (r[d] == 4'd9) begin
				r[d] = 4'd0;
			end else begin
				r[d] = r[d] + 4'd1;
				return r;
			end
		end
		return v;
	endfunction

	task automatic format_byte(input byte_t b, input logic sof);
		logic      numbered;
		logic      shown;
		out_char_t c;
		case (mode)
			MODE_ALL:      numbered = sof || after_nl;
			MODE_NONBLANK: numbered = sof || (after_nl && b != NL_BYTE);
			default:       numbered = 1'b0;
		endcase
		if (numbered) begin
			shown = 1'b0;
			for (int d = NUM_DIGITS - 1; d >= 0; d--) begin
				if (line_num[d] != 4'd0 || d == 0) begin
					shown = 1'b1;
				end
				c.data = shown ? DIGIT0_BYTE + {4'd0, line_num[d]} : SPACE_BYTE;
				c.last = 1'b0;
				formatted_q.push_back(c);
			end
			c.data = TAB_BYTE;
			c.last = 1'b0;
			formatted_q.push_back(c);
			line_num = next_line_num(line_num);
		end
		c.data = b;
		c.last = 1'b1;
		formatted_q.push_back(c);
		after_nl = (b == NL_BYTE);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_char_t want;
		if (!arst_n) begin
			mode     = MODE_ALL;
			after_nl = 1'b0;
			line_num = bcd_t'(1);
			formatted_q.delete();
		end else begin
			if (cfg_wr_en) begin
				mode = cfg_wr_data;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (formatted_q.size() == 0) begin
					report("unexpected byte", out_ch.out_byte, 0);
				end else begin
					want = formatted_q.pop_front();
					if (out_ch.out_byte !== want.data) begin
						report("out_byte", out_ch.out_byte, want.data);
					end
					if (out_ch.last !== want.last) begin
						report("last", out_ch.last, want.last);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				format_byte(in_ch.in_byte, in_ch.start_of_file);
			end
		end
		pending    <= formatted_q.size();
		fail_count <= errors;
	end

endmodule

// ===== sim/tb_text_line_numberer.sv =====
`timescale 1ns / 1ps

module tb_text_line_numberer;
	import tln_pkg::*;

	localparam logic [1:0] MODE_PASS_ALT = 2'd3;
	localparam int LIMIT      = 500000;
	localparam int LONG_HOLD  = 200;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_LEN  = 41;
	localparam logic [1:0] PHASE_MODES [NUM_PHASES] = '{
		MODE_ALL, MODE_NONBLANK, MODE_PASS, MODE_PASS_ALT,
		MODE_NONBLANK, MODE_ALL, MODE_PASS, MODE_ALL
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_wr_data;
	int         fail_count;
	int         pending;
	int         cycles = 0;
	logic       quiet = 1'b0;
	logic       hold_req = 1'b0;
	logic       last_nl = 1'b0;

	tln_in_if  in_ch();
	tln_out_if out_ch();

	text_line_numberer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	tln_tb_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int input_gap();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_byte(input byte_t b, input logic sof);
		int gap;
		in_ch.valid         <= 1'b1;
		in_ch.in_byte       <= b;
		in_ch.start_of_file <= sof;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		gap = input_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly text with short and blank lines, some raw bytes
	task automatic text_item(output byte_t b, output logic sof);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			b = byte_t'($urandom_range(0, 255));
		end else if (r < 30 || (last_nl && r < 45)) begin
			b = NL_BYTE;
		end else begin
			b = byte_t'($urandom_range(32, 126));
		end
		sof     = ($urandom_range(0, 99) < 5);
		last_nl = (b == NL_BYTE);
	endtask

	initial begin
		int    n;
		logic  held;
		held         = 1'b0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (quiet || $urandom_range(0, 99) < 60) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b0;
				n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	initial begin
		byte_t b;
		logic  sof;
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = MODE_ALL;
		in_ch.valid         = 1'b0;
		in_ch.in_byte       = '0;
		in_ch.start_of_file = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first byte after reset without start of file gets no number
		send_byte("A", 1'b0);
		send_byte(NL_BYTE, 1'b0);
		send_byte(NL_BYTE, 1'b0);
		send_byte("b", 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(NL_BYTE, 1'b0);
		send_byte(8'hFF, 1'b0);

		write_mode(MODE_NONBLANK);
		send_byte(NL_BYTE, 1'b0);
		send_byte(NL_BYTE, 1'b0);
		send_byte("c", 1'b0);
		send_byte(NL_BYTE, 1'b1);
		send_byte(NL_BYTE, 1'b1);
		send_byte("d", 1'b0);

		write_mode(MODE_PASS);
		send_byte(NL_BYTE, 1'b0);
		send_byte("e", 1'b0);
		send_byte("f", 1'b1);
		send_byte(NL_BYTE, 1'b0);

		// value 3 passes through, newline tracking goes on
		write_mode(MODE_PASS_ALT);
		send_byte(8'h55, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(NL_BYTE, 1'b0);

		write_mode(MODE_ALL);
		send_byte("g", 1'b0);
		send_byte(NL_BYTE, 1'b1);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_mode(PHASE_MODES[ph]);
			quiet    = (ph == 0);
			hold_req = (ph == 5);
			for (int k = 0; k < PHASE_LEN; k++) begin
				if (ph == 1 && k == 20) begin
					wait_idle();
				end
				text_item(b, sof);
				send_byte(b, sof);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tln_pkg.sv
sv/tln_if.sv
sv/tln_line_ctrl.sv
sv/tln_emitter.sv
sv/text_line_numberer.sv
sv/tln_checker.sv
sim/tln_checker.sv
sim/tb_text_line_numberer.sv
